>>> design/mrfc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mrfc_pkg;

  // item kinds on the slave side (tuser)
  localparam logic FUNC_REQUEST = 1'b0;
  localparam logic FUNC_REPLY   = 1'b1;

  // result kinds on the master side (tuser)
  localparam logic KIND_TX      = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  // Modbus function codes
  localparam logic [7:0] FC_READ_HOLDING = 8'd3;
  localparam logic [7:0] FC_READ_INPUT   = 8'd4;
  localparam logic [7:0] FC_WRITE_SINGLE = 8'd6;

  // reply verdicts
  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_BAD_LENGTH = 3'd1;
  localparam logic [2:0] ST_BAD_CRC    = 3'd2;
  localparam logic [2:0] ST_BAD_HEADER = 3'd3;
  localparam logic [2:0] ST_ECHO_ERR   = 3'd4;

  localparam logic [3:0]  READ_LEN       = 4'd7;
  localparam logic [3:0]  WRITE_LEN      = 4'd8;
  localparam logic [3:0]  CRC_SPAN       = 4'd5;
  localparam logic [7:0]  READ_BYTE_CNT  = 8'd2;
  localparam logic [7:0]  ADDR_RESET     = 8'd254;
  localparam logic [15:0] CRC_INIT       = 16'hFFFF;
  localparam logic [15:0] CRC_POLY       = 16'hA001;

  typedef logic [7:0] byte_t;

  // one byte of the reflected Modbus CRC-16
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input byte_t b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

>>> design/modbus_rtu_master_frame_check.sv
`timescale 1ns / 1ps
`default_nettype none

// Modbus RTU master request framer and reply checker.
// Slave side (s_*): one transaction is either a request (tuser 0: function code,
// register, value) or one received reply byte (tuser 1); tlast marks the end of
// a reply (timeout) and then carries no byte.
// Master side (m_*): tuser 0 is a request frame byte (eight per accepted request,
// tlast on the eighth, CRC low then high last); tuser 1 is a reply verdict with
// status and the read data word.
// cfg_we/cfg_wdata write the slave address; write it only while the block is idle.
// An item is held in the input register, then its result, if any, is in the output
// register; a request first loads the frame sequencer, which sends the frame
// bytes one per cycle unless m_tready stalls the output.
// The input takes one item per cycle, but a reply byte waits while the output is
// stalled, and a request holds the input for as long as its frame goes out.
// Requests with an unknown function code or a zero read count give no output.
// Reset: empty pipeline, address 254, a 7-byte read reply expected.
// A stall on m_tready holds the output register; the input register still takes
// one item, and then s_tready drops until the result can move.
module modbus_rtu_master_frame_check
  import mrfc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [7:0]  cfg_wdata,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // [7:0] function_code, [23:8] register_address, [39:24] register_value,
  // [47:40] rx_byte
  input  wire logic [47:0] s_tdata,
  input  wire logic        s_tuser,   // func
  input  wire logic        s_tlast,   // end_of_reply
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // [7:0] tx_byte, [10:8] status, [26:11] data_word, [31:27] zero
  output logic [31:0]      m_tdata,
  output logic             m_tuser,   // kind
  output logic             m_tlast    // last
);

  // input register
  logic        in_valid;
  logic        in_func;
  logic        in_eor;
  byte_t       in_fcode;
  logic [15:0] in_reg;
  logic [15:0] in_val;
  byte_t       in_rx;

  // block state
  byte_t       device_address;
  byte_t       sent_frame [8];
  byte_t       reply_bytes [8];
  logic [3:0]  reply_count;
  logic [3:0]  expected_length;
  logic        expect_echo;
  logic [15:0] reply_crc;

  // frame sequencer
  logic        frame_active;
  logic [2:0]  frame_idx;
  logic [15:0] frame_crc;

  // output register
  logic        out_kind;
  byte_t       out_tx;
  logic        out_last;
  logic [2:0]  out_status;
  logic [15:0] out_word;

  logic        out_free;
  logic        frame_fire;
  logic        take;
  logic        take_req;
  logic        take_rx;
  logic        is_read;
  logic        is_write;
  logic        req_ok;
  byte_t       fr_byte;
  logic [15:0] fr_crc_next;

  logic        wr_byte;
  logic [3:0]  reply_count_next;
  logic [15:0] reply_crc_next;
  byte_t       rb_next [8];
  logic        verdict_due;
  logic        echo_diff;
  logic [2:0]  judge_status;
  logic [15:0] judge_word;

  assign out_free   = !m_tvalid || m_tready;
  assign frame_fire = frame_active && out_free;
  assign take       = in_valid && !frame_active && (in_func == FUNC_REQUEST || out_free);
  assign take_req   = take && in_func == FUNC_REQUEST && req_ok;
  assign take_rx    = take && in_func == FUNC_REPLY;
  assign s_tready   = !in_valid || take;

  assign is_read  = (in_fcode == FC_READ_HOLDING || in_fcode == FC_READ_INPUT) &&
                    in_val != 16'd0;
  assign is_write = in_fcode == FC_WRITE_SINGLE;
  assign req_ok   = is_read || is_write;

  assign fr_byte     = sent_frame[frame_idx];
  assign fr_crc_next = crc_byte(frame_crc, fr_byte);

  // reply path: state after this byte, then the verdict on it
  always_comb begin
    wr_byte          = !in_eor && !reply_count[3];
    reply_count_next = reply_count + {3'd0, wr_byte};
    reply_crc_next   = (wr_byte && reply_count < CRC_SPAN) ? crc_byte(reply_crc, in_rx)
                                                           : reply_crc;
    for (int i = 0; i < 8; i++) begin
      rb_next[i] = (wr_byte && reply_count[2:0] == 3'(i)) ? in_rx : reply_bytes[i];
    end
    verdict_due = in_eor || !(reply_count_next < expected_length);

    echo_diff = 1'b0;
    for (int i = 0; i < 8; i++) begin
      echo_diff = echo_diff | (rb_next[i] != sent_frame[i]);
    end

    judge_word = 16'd0;
    if (expect_echo) begin
      if (reply_count_next != WRITE_LEN) begin
        judge_status = ST_BAD_LENGTH;
      end else if (echo_diff) begin
        judge_status = ST_ECHO_ERR;
      end else begin
        judge_status = ST_OK;
      end
    end else if (reply_count_next != READ_LEN) begin
      judge_status = ST_BAD_LENGTH;
    end else if (rb_next[5] != reply_crc_next[7:0] || rb_next[6] != reply_crc_next[15:8]) begin
      judge_status = ST_BAD_CRC;
    end else if (rb_next[0] != device_address ||
                 (rb_next[1] != FC_READ_HOLDING && rb_next[1] != FC_READ_INPUT) ||
                 rb_next[2] != READ_BYTE_CNT) begin
      judge_status = ST_BAD_HEADER;
    end else begin
      judge_status = ST_OK;
      judge_word   = {rb_next[3], rb_next[4]};
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid        <= 1'b0;
      m_tvalid        <= 1'b0;
      frame_active    <= 1'b0;
      frame_idx       <= 3'd0;
      device_address  <= ADDR_RESET;
      reply_count     <= 4'd0;
      reply_crc       <= CRC_INIT;
      expected_length <= READ_LEN;
      expect_echo     <= 1'b0;
    end else begin
      if (cfg_we) begin
        device_address <= cfg_wdata;
      end
      if (s_tready) begin
        in_valid <= s_tvalid;
      end
      if (frame_fire || (take_rx && verdict_due)) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (frame_fire) begin
        frame_idx <= frame_idx + 3'd1;
        if (frame_idx == 3'd7) begin
          frame_active <= 1'b0;
        end
      end
      if (take_req) begin
        frame_active    <= 1'b1;
        frame_idx       <= 3'd0;
        expect_echo     <= is_write;
        expected_length <= is_write ? WRITE_LEN : READ_LEN;
        reply_count     <= 4'd0;
        reply_crc       <= CRC_INIT;
      end
      if (take_rx) begin
        if (verdict_due) begin
          reply_count <= 4'd0;
          reply_crc   <= CRC_INIT;
        end else begin
          reply_count <= reply_count_next;
          reply_crc   <= reply_crc_next;
        end
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (s_tready) begin
      in_func  <= s_tuser;
      in_eor   <= s_tlast;
      in_fcode <= s_tdata[7:0];
      in_reg   <= s_tdata[23:8];
      in_val   <= s_tdata[39:24];
      in_rx    <= s_tdata[47:40];
    end
    if (frame_fire) begin
      out_kind   <= KIND_TX;
      out_tx     <= fr_byte;
      out_last   <= frame_idx == 3'd7;
      out_status <= ST_OK;
      out_word   <= 16'd0;
      if (frame_idx < 3'd6) begin
        frame_crc <= fr_crc_next;
      end
      if (frame_idx == 3'd5) begin
        sent_frame[6] <= fr_crc_next[7:0];
        sent_frame[7] <= fr_crc_next[15:8];
      end
    end
    if (take_req) begin
      sent_frame[0] <= device_address;
      sent_frame[1] <= in_fcode;
      sent_frame[2] <= in_reg[15:8];
      sent_frame[3] <= in_reg[7:0];
      sent_frame[4] <= in_val[15:8];
      sent_frame[5] <= in_val[7:0];
      frame_crc     <= CRC_INIT;
    end
    if (take_rx) begin
      if (verdict_due) begin
        out_kind   <= KIND_VERDICT;
        out_tx     <= 8'd0;
        out_last   <= 1'b0;
        out_status <= judge_status;
        out_word   <= judge_word;
      end
      for (int i = 0; i < 8; i++) begin
        reply_bytes[i] <= verdict_due ? 8'd0 : rb_next[i];
      end
    end
  end

  assign m_tdata = {5'd0, out_word, out_status, out_tx};
  assign m_tuser = out_kind;
  assign m_tlast = out_last;

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    reply_count <= WRITE_LEN)
    else $error("reply count beyond a full echo");

  a_restart_on_request: assert property (@(posedge clk) disable iff (rst)
    $rose(frame_active) |-> reply_count == 4'd0 && reply_crc == CRC_INIT)
    else $error("reply collection not restarted by a request");

  a_tx_fields_clear: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == KIND_TX |-> m_tdata[26:8] == 19'd0)
    else $error("frame byte carries verdict fields");

  // a held last byte keeps the sequencer at the start of a frame
  a_last_ends_frame: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == KIND_TX && m_tlast |-> frame_idx == 3'd0)
    else $error("frame sequencer moved on past a held last byte");

  a_no_take_in_frame: assert property (@(posedge clk) disable iff (rst)
    frame_active |-> !take)
    else $error("item consumed while a frame is going out");

endmodule

`default_nettype wire
